// ===== hw/rtl/pst_pkg.sv =====
// Shared types and codes for the periodic soft timer table.
// Request and result payloads, timer entry layout, and the
// command and status bundles between the controller and the datapath.
package pst_pkg;

    // Operation codes of a request
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;

    // Timer run states
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  slot_index;
        logic [15:0] start_count;
        logic [15:0] reload_period;
        logic [1:0]  run_state;
    } t_req;

    typedef struct packed {
        logic [7:0] fired_mask;
        logic [2:0] assigned_slot;
        logic       error;
        logic [3:0] timers_in_use;
    } t_rsp;

    // One timer as stored in the entry RAM
    typedef struct packed {
        logic [15:0] count;
        logic [15:0] period;
        logic [1:0]  status;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the incoming request, clear result fields
        logic exec_write;  // perform create or set
        logic start_tick;  // rewind the sweep index, read entry zero
        logic step;        // update the current entry, advance the index
        logic publish;     // load the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       used_zero;
        logic       idx_last;
        logic       out_free;
    } t_sts;

endpackage

// ===== hw/rtl/pst_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pst_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pst_ctrl.sv =====
// Sequencing state machine of the periodic soft timer table.
// Depends on pst_pkg for the command and status bundles and the op codes.
module pst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  pst_pkg::t_sts   i_sts,
    output pst_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    pst_pkg::OP_TICK: begin
                        if (i_sts.used_zero) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.start_tick = 1'b1;
                            n_state          = S_UPDATE;
                        end
                    end
                    pst_pkg::OP_CREATE, pst_pkg::OP_SET: begin
                        o_cmd.exec_write = 1'b1;
                        n_state          = S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_UPDATE: begin
                o_cmd.step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Take a new request only when idle
    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/pst_dp.sv =====
// Datapath of the periodic soft timer table: request register, entry RAM,
// slot count, tick sweep, result and output registers.
// Depends on pst_pkg and pst_ram.
module pst_dp #(
    parameter int NUM_TIMERS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pst_pkg::t_req   i_req,
    input  logic            i_stall,
    input  pst_pkg::t_cmd   i_cmd,
    output pst_pkg::t_sts   o_sts,
    output logic            o_valid,
    output pst_pkg::t_rsp   o_rsp
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int UW = $clog2(NUM_TIMERS + 1);
    localparam int EW = $bits(pst_pkg::t_entry);

    pst_pkg::t_req   r_req;
    logic [UW-1:0]   r_used;
    logic [AW-1:0]   r_idx;
    logic [7:0]      r_mask;
    logic [2:0]      r_slot;
    logic            r_err;
    logic            r_valid;
    pst_pkg::t_rsp   r_rsp;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    pst_pkg::t_entry ram_wdata;
    logic [EW-1:0]   ram_rbits;
    pst_pkg::t_entry rd_entry;
    pst_pkg::t_entry upd_entry;
    pst_pkg::t_entry new_entry;
    logic            fire;

    logic [7:0]      used8;
    logic [7:0]      slot8;
    logic [7:0]      idx8;
    logic            full;
    logic            set_ok;
    logic [UW+3:0]   used_ext;

    // Timer entries
    pst_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign rd_entry = ram_rbits;

    // Slot bookkeeping in a common width
    assign used8  = 8'(r_used);
    assign slot8  = 8'(r_req.slot_index);
    assign idx8   = 8'(r_idx);
    assign full   = (used8 >= 8'(NUM_TIMERS));
    assign set_ok = (slot8 < used8) && (slot8 < 8'(NUM_TIMERS));

    assign new_entry.count  = r_req.start_count;
    assign new_entry.period = r_req.reload_period;
    assign new_entry.status = r_req.run_state;

    // Age one active timer: fire and reload or finish at zero, else count down
    always_comb begin
        upd_entry = rd_entry;
        fire      = 1'b0;
        if (rd_entry.status == pst_pkg::ST_ACTIVE) begin
            if (rd_entry.count == 16'd0) begin
                fire = 1'b1;
                if (rd_entry.period != 16'd0) begin
                    upd_entry.count = rd_entry.period - 16'd1;
                end else begin
                    upd_entry.status = pst_pkg::ST_DONE;
                end
            end else begin
                upd_entry.count = rd_entry.count - 16'd1;
            end
        end
    end

    // Write port: sweep write-back, or create / set
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = upd_entry;
        if (i_cmd.step) begin
            ram_we = 1'b1;
        end else if (i_cmd.exec_write) begin
            ram_wdata = new_entry;
            if (r_req.op == pst_pkg::OP_CREATE) begin
                ram_we    = !full;
                ram_waddr = AW'(r_used);
            end else begin
                ram_we    = set_ok;
                ram_waddr = AW'(r_req.slot_index);
            end
        end
    end

    // Read one entry ahead of the write-back
    assign ram_raddr = i_cmd.step ? (r_idx + AW'(1)) : '0;

    // Latch the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
    end

    // Count created timers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.exec_write && r_req.op == pst_pkg::OP_CREATE && !full) begin
            r_used <= r_used + UW'(1);
        end
    end

    // Advance the sweep index
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_tick) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // Collect result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mask <= '0;
            r_slot <= '0;
            r_err  <= 1'b0;
        end else begin
            if (i_cmd.step && fire) begin
                r_mask <= r_mask | (8'd1 << r_idx);
            end
            if (i_cmd.exec_write) begin
                if (r_req.op == pst_pkg::OP_CREATE) begin
                    if (full) begin
                        r_err <= 1'b1;
                    end else begin
                        r_slot <= 3'(r_used);
                    end
                end else begin
                    r_err <= !set_ok;
                end
            end
        end
    end

    assign used_ext = {4'd0, r_used};

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_rsp.fired_mask    <= r_mask;
            r_rsp.assigned_slot <= r_slot;
            r_rsp.error         <= r_err;
            r_rsp.timers_in_use <= used_ext[3:0];
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Status to the controller
    assign o_sts.op        = r_req.op;
    assign o_sts.used_zero = (r_used == '0);
    assign o_sts.idx_last  = ((idx8 + 8'd1) == used8);
    assign o_sts.out_free  = !r_valid || !i_stall;

endmodule

// ===== hw/rtl/periodic_soft_timer_table.sv =====
// Top level of the periodic soft timer table.
// Joins pst_ctrl and pst_dp; payload types come from pst_pkg.
//
// A table of up to NUM_TIMERS software timers, each with a 16-bit count,
// a 16-bit reload period and a run state, held in a small RAM. Every request
// gives exactly one result. Requests are handled one at a time; a tick
// sweeps the created entries through the single read port of the entry
// RAM, one entry per cycle, with each write-back overlapped with the read
// of the next entry. A result waits in an output register; if it is still
// held there, the next request is taken but its result waits until the
// register frees. Entry storage is not cleared at reset; only entries of
// created slots affect results.
module periodic_soft_timer_table #(
    parameter int NUM_TIMERS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pst_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output pst_pkg::t_rsp  o_rsp
);

    pst_pkg::t_cmd cmd;
    pst_pkg::t_sts sts;

    pst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pst_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stall (i_stall),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== hw/rtl/pst_checker.sv =====
// Port-level checks for the periodic soft timer table, bound to the top level.
// Depends on pst_pkg for the payload types.
module pst_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input pst_pkg::t_rsp o_rsp
);

    // A held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // The block is busy right after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken while still busy");

    // A failed request reports no slot and no firing
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.error |-> o_rsp.assigned_slot == 3'd0 &&
                                   o_rsp.fired_mask == 8'd0)
        else $error("error result carries other fields");

    // Firing only comes from a tick
    a_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.fired_mask != 8'd0 |-> o_rsp.assigned_slot == 3'd0 &&
                                                !o_rsp.error)
        else $error("tick result mixed with create or set fields");

endmodule

bind periodic_soft_timer_table pst_checker u_pst_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);

// ===== verif/tb_periodic_soft_timer_table.sv =====
// Self-checking testbench for the periodic soft timer table.
// Predicts every result from its own copy of the timer table and checks each one;
// depends on pst_pkg and periodic_soft_timer_table.
module tb_periodic_soft_timer_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TIMERS = 8;

    // Codes the package leaves out
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_BOGUS   = 2'd3;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    pst_pkg::t_req i_req;
    logic          o_valid;
    logic          i_stall;
    pst_pkg::t_rsp o_rsp;

    // Shadow timer table
    logic [15:0] shadow_count  [NUM_TIMERS];
    logic [15:0] shadow_period [NUM_TIMERS];
    logic [1:0]  shadow_status [NUM_TIMERS];
    int unsigned shadow_used;

    pst_pkg::t_rsp pending_rsp[$];
    int            mismatch_count = 0;
    int            idle_pct = 0;

    periodic_soft_timer_table #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Apply one request to the shadow table and return its result
    function automatic pst_pkg::t_rsp advance_timer_table(input pst_pkg::t_req req);
        pst_pkg::t_rsp rsp;
        int            idx;
        rsp = '0;
        case (req.op)
            pst_pkg::OP_TICK: begin
                for (idx = 0; idx < NUM_TIMERS; idx++) begin
                    if (idx < shadow_used && shadow_status[idx] == pst_pkg::ST_ACTIVE) begin
                        if (shadow_count[idx] == 16'd0) begin
                            if (idx < 8) rsp.fired_mask[idx] = 1'b1;
                            if (shadow_period[idx] != 16'd0)
                                shadow_count[idx] = shadow_period[idx] - 16'd1;
                            else
                                shadow_status[idx] = pst_pkg::ST_DONE;
                        end else begin
                            shadow_count[idx] = shadow_count[idx] - 16'd1;
                        end
                    end
                end
            end
            pst_pkg::OP_CREATE: begin
                if (shadow_used >= NUM_TIMERS) begin
                    rsp.error = 1'b1;
                end else begin
                    shadow_count[shadow_used]  = req.start_count;
                    shadow_period[shadow_used] = req.reload_period;
                    shadow_status[shadow_used] = req.run_state;
                    rsp.assigned_slot = shadow_used[2:0];
                    shadow_used++;
                end
            end
            pst_pkg::OP_SET: begin
                if (req.slot_index >= shadow_used || req.slot_index >= NUM_TIMERS) begin
                    rsp.error = 1'b1;
                end else begin
                    shadow_count[req.slot_index]  = req.start_count;
                    shadow_period[req.slot_index] = req.reload_period;
                    shadow_status[req.slot_index] = req.run_state;
                end
            end
            default: ;
        endcase
        rsp.timers_in_use = shadow_used[3:0];
        return rsp;
    endfunction

    function automatic pst_pkg::t_req make_req(input logic [1:0] op, input logic [2:0] slot,
                                               input logic [15:0] count,
                                               input logic [15:0] period,
                                               input logic [1:0] state);
        pst_pkg::t_req req;
        req.op            = op;
        req.slot_index    = slot;
        req.start_count   = count;
        req.reload_period = period;
        req.run_state     = state;
        return req;
    endfunction

    // Mostly short counts so timers fire often, now and then the full range
    function automatic logic [15:0] pick_ticks();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 16'd0;
        if (roll < 65) return 16'($urandom_range(1, 6));
        if (roll < 90) return 16'($urandom_range(7, 40));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic pst_pkg::t_req random_request();
        pst_pkg::t_req req;
        int unsigned   roll;
        logic [1:0]    state;
        roll  = $urandom_range(0, 99);
        state = ($urandom_range(0, 99) < 70) ? pst_pkg::ST_ACTIVE
                                             : 2'($urandom_range(0, 3));
        req   = make_req(pst_pkg::OP_TICK, 3'($urandom_range(0, 7)), pick_ticks(),
                         pick_ticks(), state);
        if (roll >= 55 && roll < 90)
            req.op = pst_pkg::OP_SET;
        else if (roll >= 90 && roll < 95)
            req.op = pst_pkg::OP_CREATE;
        else if (roll >= 95)
            req.op = OP_UNUSED;
        return req;
    endfunction

    // Hand one request to the block and log its expected result at acceptance
    task automatic issue_request(input pst_pkg::t_req req);
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_rsp.push_back(advance_timer_table(req));
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Hold off the result side in random bursts
    initial begin : drive_result_stall
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        pst_pkg::t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result %h with no request outstanding", o_rsp);
                mismatch_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.fired_mask !== want.fired_mask) begin
                    $error("fired_mask: expected %0h, got %0h", want.fired_mask,
                           o_rsp.fired_mask);
                    mismatch_count++;
                end
                if (o_rsp.assigned_slot !== want.assigned_slot) begin
                    $error("assigned_slot: expected %0d, got %0d", want.assigned_slot,
                           o_rsp.assigned_slot);
                    mismatch_count++;
                end
                if (o_rsp.error !== want.error) begin
                    $error("error: expected %0b, got %0b", want.error, o_rsp.error);
                    mismatch_count++;
                end
                if (o_rsp.timers_in_use !== want.timers_in_use) begin
                    $error("timers_in_use: expected %0d, got %0d", want.timers_in_use,
                           o_rsp.timers_in_use);
                    mismatch_count++;
                end
            end
        end
    end

    // Tick, set and the unused opcode against an empty table
    task automatic test_empty_table();
        issue_request(make_req(pst_pkg::OP_TICK, 3'd0, 16'd0, 16'd0, pst_pkg::ST_ACTIVE));
        issue_request(make_req(pst_pkg::OP_SET, 3'd0, 16'd5, 16'd5, pst_pkg::ST_ACTIVE));
        issue_request(make_req(pst_pkg::OP_SET, 3'd7, 16'hFFFF, 16'hFFFF, ST_BOGUS));
        issue_request(make_req(OP_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF, ST_BOGUS));
    endtask

    // Fill every slot with a different flavor of timer, then overflow the table
    task automatic test_fill_table();
        issue_request(make_req(pst_pkg::OP_CREATE, 3'd5, 16'd0, 16'd0, pst_pkg::ST_ACTIVE));
        issue_request(make_req(pst_pkg::OP_CREATE, 3'd0, 16'd0, 16'd1, pst_pkg::ST_ACTIVE));
        issue_request(make_req(pst_pkg::OP_CREATE, 3'd7, 16'hFFFF, 16'hFFFF,
                               pst_pkg::ST_ACTIVE));
        issue_request(make_req(pst_pkg::OP_SET, 3'd5, 16'd1, 16'd1, pst_pkg::ST_ACTIVE));
        issue_request(make_req(pst_pkg::OP_CREATE, 3'd0, 16'd2, 16'd3, pst_pkg::ST_ACTIVE));
        issue_request(make_req(pst_pkg::OP_CREATE, 3'd0, 16'd1, 16'd0, ST_BOGUS));
        issue_request(make_req(pst_pkg::OP_CREATE, 3'd0, 16'd0, 16'd2, ST_STOPPED));
        issue_request(make_req(pst_pkg::OP_CREATE, 3'd0, 16'd0, 16'd0, pst_pkg::ST_DONE));
        issue_request(make_req(pst_pkg::OP_CREATE, 3'd0, 16'h5A5A, 16'hA5A5,
                               pst_pkg::ST_ACTIVE));
        issue_request(make_req(pst_pkg::OP_CREATE, 3'd0, 16'd3, 16'd3, pst_pkg::ST_ACTIVE));
    endtask

    // Watch one-shot, periodic, stopped and odd-state timers across ticks
    task automatic test_tick_behavior();
        repeat (4)
            issue_request(make_req(pst_pkg::OP_TICK, 3'd7, 16'hFFFF, 16'hFFFF, ST_BOGUS));
        issue_request(make_req(pst_pkg::OP_SET, 3'd0, 16'd0, 16'd0, pst_pkg::ST_ACTIVE));
        issue_request(make_req(pst_pkg::OP_SET, 3'd7, 16'd0, 16'hFFFF, pst_pkg::ST_ACTIVE));
        issue_request(make_req(pst_pkg::OP_TICK, 3'd0, 16'd0, 16'd0, ST_STOPPED));
        issue_request(make_req(pst_pkg::OP_TICK, 3'd0, 16'd0, 16'd0, ST_STOPPED));
    endtask

    // Random ticks, rewrites, creates and unused opcodes in phases of varying idle pressure
    task automatic test_random_traffic();
        int phase;
        int pct_choice [4] = '{0, 10, 30, 60};
        for (phase = 0; phase < 14; phase++) begin
            idle_pct = pct_choice[$urandom_range(0, 3)];
            repeat (100) issue_request(random_request());
        end
    endtask

    // Back-to-back requests with both sides always ready
    task automatic test_steady_stream();
        idle_pct = 0;
        repeat (150) issue_request(random_request());
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req   <= '0;
        shadow_used = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 30;
        test_empty_table();
        test_fill_table();
        test_tick_behavior();
        test_random_traffic();
        test_steady_stream();

        // Drain outstanding results, then watch for strays
        i_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
